// ===== design/haptic_alert_tone_sequencer_defines.svh =====
// Assertion macros shared by the haptic alert tone sequencer RTL.
`ifndef HAPTIC_ALERT_TONE_SEQUENCER_DEFINES_SVH
`define HAPTIC_ALERT_TONE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HATS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HATS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hats_pkg.sv =====
// Types, codes and constants for the haptic alert tone sequencer.
package hats_pkg;

   localparam int unsigned NOW_W      = 32;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned SPEED_W    = 9;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned HALF_W     = 9;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Only phase bits up to the slow-pattern bit matter.
   localparam int unsigned PHASE_W        = 26;
   localparam int unsigned FAST_PHASE_BIT = 23;
   localparam int unsigned SLOW_PHASE_BIT = 25;

   // 1/16 s in Q16.16
   localparam logic [NOW_W-1:0] BEEP_HALF_PERIOD = 32'd4096;

   localparam logic [SPEED_W-1:0] SPEED_ONE = 9'd256;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_ALERT = 1'b1
   } hats_op_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2
   } hats_act_type;

   typedef enum logic [1:0] {
      PAT_NONE   = 2'd0,
      PAT_FAST   = 2'd1,
      PAT_SLOW   = 2'd2,
      PAT_STEADY = 2'd3
   } hats_pat_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_RATE    = 3'd0,
      CSR_TONE_FREQUENCY  = 3'd1,
      CSR_BASE_STRENGTH   = 3'd2,
      CSR_FULL_STRENGTH   = 3'd3,
      CSR_BEEPER_LEVEL    = 3'd4
   } hats_csr_type;

   typedef struct packed {
      hats_op_type          opcode;
      logic [NOW_W-1:0]     now;
      logic [3:0]           warning_class;
      logic                 running;
      logic [SPEED_W-1:0]   speed_factor;
      logic [COUNT_W-1:0]   beep_count;
   } hats_req_type;

   typedef struct packed {
      hats_act_type         tone_action;
      logic [LEVEL_W-1:0]   tone_amplitude;
      hats_act_type         beeper_action;
      logic [LEVEL_W-1:0]   beeper_amplitude;
   } hats_rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   pattern_rate;
      logic [LEVEL_W-1:0]   base_strength;
      logic [LEVEL_W-1:0]   strength_at_full_speed;
      logic [LEVEL_W-1:0]   beeper_level;
   } hats_cfg_type;

   // Per-cycle step control from the top level to the state units.
   typedef struct packed {
      logic fire;
      logic alert;
   } hats_step_type;

endpackage

// ===== design/haptic_alert_tone_sequencer.sv =====
// Top level of the haptic alert tone sequencer.
//
// Requests come in on req_valid/req_stall/req_payload; each one is a tick
// (current time, warning class, running flag, speed factor) or an alert
// request (beep count). Every request gives exactly one response on
// rsp_valid/rsp_stall/rsp_payload: a haptic tone action with amplitude and
// a beeper action with amplitude; alert requests answer with all zeros.
// Settings come in over csr_we/csr_index/csr_wdata, one 16-bit register
// per write, and must only be changed while no request is in flight.
// A request is held in the input register and then in the response
// register, which drives rsp_valid.
// Throughput: one request per cycle while rsp_stall is low. The pattern multiply, the amplitude
// blend and all state updates sit in one combinational pass between the
// input register and the response register.
// Stalls: the response register holds while it is full and rsp_stall is high; the input
// register then fills and req_stall rises only once both are occupied.
// Reset (synchronous, active high) clears both valid flags, the tone and
// beeper state, the beep counter and edge time, and all settings to zero.
// The tone frequency register is accepted but drives no output.
module haptic_alert_tone_sequencer
   import hats_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hats_req_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hats_rsp_type          rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   `include "haptic_alert_tone_sequencer_defines.svh"

   hats_cfg_type  cfg_ff;
   hats_cfg_type  cfg_in;
   logic          s1_valid;
   hats_req_type  s1_payload;
   logic          advance;
   hats_step_type step;
   hats_rsp_type  rsp_ff;
   hats_rsp_type  rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Settings registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (hats_csr_type'(csr_index))
            CSR_PATTERN_RATE:   cfg_in.pattern_rate           = csr_wdata;
            CSR_BASE_STRENGTH:  cfg_in.base_strength          = csr_wdata;
            CSR_FULL_STRENGTH:  cfg_in.strength_at_full_speed = csr_wdata;
            CSR_BEEPER_LEVEL:   cfg_in.beeper_level           = csr_wdata;
            default:            cfg_in = cfg_ff;  // tone frequency, unused codes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Work moves out of the input register when the response slot is free.
   assign advance    = s1_valid && (!rsp_valid_ff || !rsp_stall);
   assign step.fire  = advance;
   assign step.alert = (s1_payload.opcode == OP_ALERT);

   hats_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .s1_valid    (s1_valid),
      .s1_payload  (s1_payload)
   );

   hats_tone_unit u_tone_unit (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (s1_payload),
      .cfg            (cfg_ff),
      .tone_action    (rsp_in.tone_action),
      .tone_amplitude (rsp_in.tone_amplitude)
   );

   hats_beep_unit u_beep_unit (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .item             (s1_payload),
      .cfg              (cfg_ff),
      .beeper_action    (rsp_in.beeper_action),
      .beeper_amplitude (rsp_in.beeper_amplitude)
   );

   // Response register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `HATS_ASSERT_NOW(a_stall_needs_full_stage, req_stall, s1_valid,
      "request stalled with an empty input stage")
   `HATS_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid,
      "advanced request did not reach the response register")
   `HATS_ASSERT_NOW(a_tone_amp_only_on_start,
      rsp_valid && (rsp_payload.tone_action != ACT_START),
      rsp_payload.tone_amplitude == '0,
      "tone amplitude set without a tone start")
   `HATS_ASSERT_NOW(a_beep_amp_only_on_start,
      rsp_valid && (rsp_payload.beeper_action != ACT_START),
      rsp_payload.beeper_amplitude == '0,
      "beeper amplitude set without a beeper start")

endmodule

// ===== design/hats_req_stage.sv =====
// Input register stage holding the request under work.
module hats_req_stage
   import hats_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hats_req_type req_payload,
   input  logic         advance,
   output logic         s1_valid,
   output hats_req_type s1_payload
);

   logic         valid_ff;
   logic         valid_in;
   hats_req_type payload_ff;
   logic         load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= req_payload;
      end
   end

   assign s1_valid   = valid_ff;
   assign s1_payload = payload_ff;

endmodule

// ===== design/hats_tone_unit.sv =====
// Buzz pattern decode, haptic tone state and speed-blended amplitude.
module hats_tone_unit
   import hats_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hats_step_type      step,
   input  hats_req_type       item,
   input  hats_cfg_type       cfg,
   output hats_act_type       tone_action,
   output logic [LEVEL_W-1:0] tone_amplitude
);

   logic               tone_on_ff;
   logic               tone_on_in;
   hats_pat_type       pattern;
   logic [PHASE_W-1:0] phase;
   logic               want_tone;
   logic [SPEED_W-1:0] f_sat;
   logic [SPEED_W-1:0] f_inv;
   logic [24:0]        lo_part;
   logic [24:0]        hi_part;
   logic [24:0]        mix;

   always_comb begin
      if (!item.running) begin
         pattern = PAT_NONE;
      end else begin
         case (item.warning_class) inside
            4'd1, 4'd2:   pattern = PAT_FAST;
            [4'd3:4'd6]:  pattern = PAT_SLOW;
            4'd7, 4'd8:   pattern = PAT_STEADY;
            default:      pattern = PAT_NONE;
         endcase
      end
   end

   // Low bits of now * rate (Q24.24); higher bits never reach the pattern decode.
   assign phase = PHASE_W'(item.now[PHASE_W-1:0] * cfg.pattern_rate);

   always_comb begin
      case (pattern)
         PAT_FAST:   want_tone = !phase[FAST_PHASE_BIT];
         PAT_SLOW:   want_tone = !phase[SLOW_PHASE_BIT];
         PAT_STEADY: want_tone = 1'b1;
         default:    want_tone = 1'b0;
      endcase
   end

   assign f_sat   = (item.speed_factor > SPEED_ONE) ? SPEED_ONE : item.speed_factor;
   assign f_inv   = SPEED_ONE - f_sat;
   assign lo_part = 25'(cfg.base_strength) * 25'(f_inv);
   assign hi_part = 25'(cfg.strength_at_full_speed) * 25'(f_sat);
   assign mix     = lo_part + hi_part + 25'd128;

   always_comb begin
      tone_action    = ACT_NONE;
      tone_amplitude = '0;
      tone_on_in     = tone_on_ff;
      if (!step.alert) begin
         if (tone_on_ff && !want_tone) begin
            tone_action = ACT_STOP;
            tone_on_in  = 1'b0;
         end else if (!tone_on_ff && want_tone) begin
            tone_action    = ACT_START;
            tone_amplitude = mix[23:8];
            tone_on_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_on_ff <= 1'b0;
      end else if (step.fire) begin
         tone_on_ff <= tone_on_in;
      end
   end

endmodule

// ===== design/hats_beep_unit.sv =====
// Alert beeper: half-period counter, edge time and start/stop state.
module hats_beep_unit
   import hats_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hats_step_type      step,
   input  hats_req_type       item,
   input  hats_cfg_type       cfg,
   output hats_act_type       beeper_action,
   output logic [LEVEL_W-1:0] beeper_amplitude
);

   logic              beeper_on_ff;
   logic              beeper_on_in;
   logic [HALF_W-1:0] half_ff;
   logic [HALF_W-1:0] half_in;
   logic [NOW_W-1:0]  edge_ff;
   logic [NOW_W-1:0]  edge_in;
   logic [NOW_W-1:0]  next_edge;
   logic [HALF_W-1:0] half_dec;
   logic              want_beep;

   assign next_edge = item.now + BEEP_HALF_PERIOD;
   assign half_dec  = half_ff - 9'd1;

   always_comb begin
      half_in          = half_ff;
      edge_in          = edge_ff;
      beeper_on_in     = beeper_on_ff;
      beeper_action    = ACT_NONE;
      beeper_amplitude = '0;
      want_beep        = 1'b0;
      if (step.alert) begin
         // 2n-1 half-periods; zero beeps clears the counter
         if (item.beep_count == '0) begin
            half_in = '0;
         end else begin
            half_in = {item.beep_count, 1'b0} - 9'd1;
         end
         edge_in = next_edge;
      end else begin
         if (half_ff != '0) begin
            want_beep = half_ff[0];
            if (item.now >= edge_ff) begin
               half_in = half_dec;
               if (half_dec != '0) begin
                  edge_in = next_edge;
               end
            end
         end
         if (beeper_on_ff && !want_beep) begin
            beeper_action = ACT_STOP;
            beeper_on_in  = 1'b0;
         end else if (!beeper_on_ff && want_beep) begin
            beeper_action    = ACT_START;
            beeper_amplitude = cfg.beeper_level;
            beeper_on_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beeper_on_ff <= 1'b0;
         half_ff      <= '0;
         edge_ff      <= '0;
      end else if (step.fire) begin
         beeper_on_ff <= beeper_on_in;
         half_ff      <= half_in;
         edge_ff      <= edge_in;
      end
   end

endmodule
